[hw/rtl/bar_moving_average_bank_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the bar moving average bank
// Concurrent checks clocked by clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef BAR_MOVING_AVERAGE_BANK_MACROS_SVH
`define BAR_MOVING_AVERAGE_BANK_MACROS_SVH
`ifndef SYNTH
`define BMAB_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BMAB_ASSERT_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define BMAB_ASSERT(name, prop, msg)
`define BMAB_ASSERT_NEVER(name, expr, msg)
`endif
`endif

[hw/rtl/bmab_pkg.sv]
// ----------------------------------------------------------------------------
// Moving average bank package
// Sizes, codes, shared types and helper functions of the averaging bank.
// ----------------------------------------------------------------------------
package bmab_pkg;

  localparam int HIST_DEPTH   = 256;
  localparam int PRICE_BITS   = 32;
  localparam int SMA_CHANNELS = 2;
  localparam int EMA_CHANNELS = 2;

  localparam int ADDR_BITS      = $clog2(HIST_DEPTH);
  localparam int FILL_BITS      = $clog2(HIST_DEPTH + 1);
  localparam int LEN_BITS       = 8;
  localparam int ALPHA_BITS     = 16;
  localparam int FRAC_BITS      = 16;
  localparam int SUM_BITS       = 40;
  localparam int AVG_BITS       = 32;
  localparam int EMA_BITS       = 48;
  localparam int ACC_BITS       = EMA_BITS + FRAC_BITS;
  localparam int MULT_BITS      = ALPHA_BITS + 1;
  localparam int DIV_STEP_BITS  = $clog2(SUM_BITS);
  localparam int MULT_STEP_BITS = $clog2(MULT_BITS);
  localparam int RD_BITS        = $clog2(SMA_CHANNELS + 1);
  localparam int CFG_ADDR_BITS  = 4;
  localparam int CFG_DATA_BITS  = 16;
  localparam int MIN_LENGTH     = 2;

  localparam logic [LEN_BITS-1:0]   SMA0_LEN_RESET  = LEN_BITS'(10);
  localparam logic [LEN_BITS-1:0]   SMAN_LEN_RESET  = LEN_BITS'(20);
  localparam logic [ALPHA_BITS-1:0] EMA0_ALPHA_RESET = ALPHA_BITS'(10082);
  localparam logic [ALPHA_BITS-1:0] EMAN_ALPHA_RESET = ALPHA_BITS'(4855);

  typedef enum logic [1:0] {
    SRC_OPEN  = 2'd0,
    SRC_HIGH  = 2'd1,
    SRC_LOW   = 2'd2,
    SRC_CLOSE = 2'd3
  } src_e;

  typedef enum logic [0:0] {
    FLD_PARAM  = 1'b0,
    FLD_SOURCE = 1'b1
  } cfg_field_e;

  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_LOAD,
    TOP_RUN,
    TOP_OUT
  } top_state_e;

  typedef enum logic [1:0] {
    SMA_IDLE,
    SMA_ADD,
    SMA_SUB,
    SMA_DIV
  } sma_state_e;

  typedef enum logic [1:0] {
    EMA_IDLE,
    EMA_MUL_OLD,
    EMA_MUL_NEW
  } ema_state_e;

  typedef struct packed {
    logic [PRICE_BITS-1:0] open_price;
    logic [PRICE_BITS-1:0] high_price;
    logic [PRICE_BITS-1:0] low_price;
    logic [PRICE_BITS-1:0] close_price;
  } bar_t;

  localparam int BAR_BITS = $bits(bar_t);

  typedef struct packed {
    logic start;
    logic clear;
    logic capture;
  } sma_ctrl_t;

  typedef struct packed {
    logic                busy;
    logic                full;
    logic [AVG_BITS-1:0] average;
  } sma_stat_t;

  typedef struct packed {
    logic                busy;
    logic                seeded;
    logic [EMA_BITS-1:0] value;
  } ema_stat_t;

  function automatic logic [PRICE_BITS-1:0] pick_price(input bar_t bar, input src_e src);
    logic [PRICE_BITS-1:0] price;
    unique case (src)
      SRC_OPEN:  price = bar.open_price;
      SRC_HIGH:  price = bar.high_price;
      SRC_LOW:   price = bar.low_price;
      SRC_CLOSE: price = bar.close_price;
    endcase
    return price;
  endfunction

  function automatic logic [LEN_BITS-1:0] eff_length(input logic [LEN_BITS-1:0] len);
    logic [LEN_BITS-1:0] res;
    res = len;
    if (int'(len) < MIN_LENGTH) res = LEN_BITS'(MIN_LENGTH);
    if (int'(res) > HIST_DEPTH - 1) res = LEN_BITS'(HIST_DEPTH - 1);
    return res;
  endfunction

  function automatic logic [ADDR_BITS-1:0] back_slot(input logic [ADDR_BITS-1:0] newest,
                                                     input logic [LEN_BITS-1:0] back);
    logic [ADDR_BITS:0] diff;
    diff = {1'b0, newest} - (ADDR_BITS + 1)'(back);
    if (diff[ADDR_BITS]) begin
      diff = diff + (ADDR_BITS + 1)'(HIST_DEPTH);
    end
    return diff[ADDR_BITS-1:0];
  endfunction

  function automatic logic [CFG_ADDR_BITS-1:0] sma_reg(input int ch, input cfg_field_e fld);
    return CFG_ADDR_BITS'(2 * ch + int'(fld));
  endfunction

  function automatic logic [CFG_ADDR_BITS-1:0] ema_reg(input int ch, input cfg_field_e fld);
    return CFG_ADDR_BITS'(2 * SMA_CHANNELS + 2 * ch + int'(fld));
  endfunction

endpackage

[hw/rtl/bmab_if.sv]
// ----------------------------------------------------------------------------
// Moving average bank channels
// Valid/ready channels for bars, results and register writes.
// ----------------------------------------------------------------------------
interface bmab_bar_if import bmab_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [PRICE_BITS-1:0] open_price;
  logic [PRICE_BITS-1:0] high_price;
  logic [PRICE_BITS-1:0] low_price;
  logic [PRICE_BITS-1:0] close_price;

  modport source (output valid, output open_price, output high_price, output low_price,
                  output close_price, input ready);
  modport sink (input valid, input open_price, input high_price, input low_price,
                input close_price, output ready);
endinterface

interface bmab_res_if import bmab_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [AVG_BITS-1:0]  sma0_average;
  logic                 sma0_ready;
  logic [AVG_BITS-1:0]  sma1_average;
  logic                 sma1_ready;
  logic [EMA_BITS-1:0]  ema0_value;
  logic                 ema0_ready;
  logic [EMA_BITS-1:0]  ema1_value;
  logic                 ema1_ready;
  logic [FILL_BITS-1:0] bars_held;

  modport source (output valid, output sma0_average, output sma0_ready, output sma1_average,
                  output sma1_ready, output ema0_value, output ema0_ready, output ema1_value,
                  output ema1_ready, output bars_held, input ready);
  modport sink (input valid, input sma0_average, input sma0_ready, input sma1_average,
                input sma1_ready, input ema0_value, input ema0_ready, input ema1_value,
                input ema1_ready, input bars_held, output ready);
endinterface

interface bmab_cfg_if import bmab_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_ADDR_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[hw/rtl/bmab_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bmab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hw/rtl/bmab_sma_lane.sv]
// ----------------------------------------------------------------------------
// Simple moving average lane
// Running window sum with a bit-serial restoring divider by the length.
// ----------------------------------------------------------------------------
module bmab_sma_lane import bmab_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sma_ctrl_t           ctrl_i,
  input  logic [LEN_BITS-1:0] length_i,
  input  src_e                source_i,
  input  bar_t                new_bar_i,
  input  bar_t                old_bar_i,
  output sma_stat_t           stat_o
);

  sma_state_e               state_q, state_d;
  logic [SUM_BITS-1:0]      sum_q, sum_d;
  logic [LEN_BITS-1:0]      count_q, count_d;
  logic [PRICE_BITS-1:0]    old_q;
  logic [SUM_BITS-1:0]      quo_q, quo_d;
  logic [LEN_BITS-1:0]      rem_q, rem_d;
  logic [DIV_STEP_BITS-1:0] step_q, step_d;
  logic [LEN_BITS-1:0]      eff_len;
  logic [PRICE_BITS-1:0]    new_price;
  logic [LEN_BITS:0]        trial;
  logic                     fits;
  logic                     not_full;

  assign eff_len   = eff_length(length_i);
  assign new_price = pick_price(new_bar_i, source_i);
  assign not_full  = count_q < eff_len;
  assign trial     = {rem_q, quo_q[SUM_BITS-1]};
  assign fits      = trial >= {1'b0, eff_len};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SMA_IDLE: if (ctrl_i.start) state_d = SMA_ADD;
      SMA_ADD:  state_d = not_full ? SMA_DIV : SMA_SUB;
      SMA_SUB:  state_d = SMA_DIV;
      SMA_DIV:  if (step_q == '0) state_d = SMA_IDLE;
    endcase
  end

  always_comb begin
    sum_d   = sum_q;
    count_d = count_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    step_d  = step_q;
    unique case (state_q)
      SMA_IDLE: begin
        if (ctrl_i.clear) begin
          sum_d   = '0;
          count_d = '0;
        end
      end
      SMA_ADD: begin
        sum_d = sum_q + SUM_BITS'(new_price);
        if (not_full) begin
          count_d = count_q + LEN_BITS'(1);
          quo_d   = sum_d;
          rem_d   = '0;
          step_d  = DIV_STEP_BITS'(SUM_BITS - 1);
        end
      end
      SMA_SUB: begin
        sum_d  = sum_q - SUM_BITS'(old_q);
        quo_d  = sum_d;
        rem_d  = '0;
        step_d = DIV_STEP_BITS'(SUM_BITS - 1);
      end
      SMA_DIV: begin
        rem_d  = fits ? LEN_BITS'(trial - {1'b0, eff_len}) : LEN_BITS'(trial);
        quo_d  = {quo_q[SUM_BITS-2:0], fits};
        step_d = step_q - DIV_STEP_BITS'(1);
      end
    endcase
  end

  always_comb begin
    stat_o.busy    = state_q != SMA_IDLE;
    stat_o.full    = !not_full;
    stat_o.average = not_full ? '0 : quo_q[AVG_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SMA_IDLE;
      sum_q   <= '0;
      count_q <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      sum_q   <= sum_d;
      count_q <= count_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (ctrl_i.capture) begin
      old_q <= pick_price(old_bar_i, source_i);
    end
  end

endmodule

[hw/rtl/bmab_ema_lane.sv]
// ----------------------------------------------------------------------------
// Exponential moving average lane
// Seeds on the first price, then blends with a bit-serial shift-add multiplier.
// ----------------------------------------------------------------------------
module bmab_ema_lane import bmab_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [ALPHA_BITS-1:0] alpha_i,
  input  src_e                  source_i,
  input  bar_t                  new_bar_i,
  output ema_stat_t             stat_o
);

  localparam logic [MULT_BITS-1:0] MULT_ONE   = MULT_BITS'(1) << FRAC_BITS;
  localparam logic [ACC_BITS-1:0]  ROUND_HALF = ACC_BITS'(1) << (FRAC_BITS - 1);

  ema_state_e                state_q, state_d;
  logic [EMA_BITS-1:0]       value_q, value_d;
  logic                      seeded_q, seeded_d;
  logic [ACC_BITS-1:0]       acc_q, acc_d;
  logic [ACC_BITS-1:0]       mcand_q, mcand_d;
  logic [MULT_BITS-1:0]      mplier_q, mplier_d;
  logic [MULT_STEP_BITS-1:0] step_q, step_d;
  logic [ACC_BITS-1:0]       acc_sum;
  logic [PRICE_BITS-1:0]     price;
  logic                      last_step;

  assign price     = pick_price(new_bar_i, source_i);
  assign last_step = step_q == '0;
  assign acc_sum   = mplier_q[0] ? acc_q + mcand_q : acc_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      EMA_IDLE:    if (start_i && seeded_q) state_d = EMA_MUL_OLD;
      EMA_MUL_OLD: if (last_step) state_d = EMA_MUL_NEW;
      EMA_MUL_NEW: if (last_step) state_d = EMA_IDLE;
      default:     state_d = EMA_IDLE;
    endcase
  end

  always_comb begin
    value_d  = value_q;
    seeded_d = seeded_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    step_d   = step_q;
    unique case (state_q)
      EMA_IDLE: begin
        if (start_i && seeded_q) begin
          acc_d    = ROUND_HALF;
          mcand_d  = ACC_BITS'(value_q);
          mplier_d = MULT_ONE - MULT_BITS'(alpha_i);
          step_d   = MULT_STEP_BITS'(MULT_BITS - 1);
        end else if (start_i) begin
          value_d  = EMA_BITS'(ACC_BITS'(price) << FRAC_BITS);
          seeded_d = 1'b1;
        end
      end
      EMA_MUL_OLD: begin
        acc_d = acc_sum;
        if (last_step) begin
          mcand_d  = ACC_BITS'(price) << FRAC_BITS;
          mplier_d = MULT_BITS'(alpha_i);
          step_d   = MULT_STEP_BITS'(MULT_BITS - 1);
        end else begin
          mcand_d  = mcand_q << 1;
          mplier_d = mplier_q >> 1;
          step_d   = step_q - MULT_STEP_BITS'(1);
        end
      end
      EMA_MUL_NEW: begin
        acc_d    = acc_sum;
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        step_d   = step_q - MULT_STEP_BITS'(1);
        if (last_step) begin
          value_d = acc_sum[ACC_BITS-1:FRAC_BITS];
        end
      end
      default: begin
        step_d = '0;
      end
    endcase
  end

  always_comb begin
    stat_o.busy   = state_q != EMA_IDLE;
    stat_o.seeded = seeded_q;
    stat_o.value  = value_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= EMA_IDLE;
      value_q  <= '0;
      seeded_q <= 1'b0;
      step_q   <= '0;
    end else begin
      state_q  <= state_d;
      value_q  <= value_d;
      seeded_q <= seeded_d;
      step_q   <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

endmodule

[hw/rtl/bar_moving_average_bank.sv]
// ----------------------------------------------------------------------------
// Bar moving average bank
// Each accepted bar (open, high, low, close) is written into a ring history
// and updates two simple and two exponential moving averages; one result beat
// follows every bar. After acceptance the bank writes the bar and reads the
// expiring bars through the single history read port, then starts the lanes.
// The simple-average lanes take longest, set by the 40-step bit-serial
// division of the window sum; the exponential lanes finish their 34-step
// serial multiply before them. The bank then sees the lanes idle and loads
// the output register while returning to idle, once the result side has
// room. A new bar is taken only after the previous one has reached the
// output register, which then waits for its beat independently. Averages
// over a window that is not yet full read as zero with their ready flag low.
// Exponential values are Q32.16, rounded half up. Writing a simple channel's
// length or source restarts its window if the lane is idle; a write while
// the lane is busy changes the setting without a restart. Writing an
// exponential channel's weight or source takes effect with the next bar, and
// can already reach the bar in progress if written while the lane is busy.
// There is no clearing pass after reset.
// ----------------------------------------------------------------------------
`include "bar_moving_average_bank_macros.svh"

module bar_moving_average_bank import bmab_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  bmab_cfg_if.sink    cfg_i,
  bmab_bar_if.sink    bar_i,
  bmab_res_if.source  res_o
);

  top_state_e             state_q, state_d;
  logic [RD_BITS-1:0]     rd_q, rd_d;
  logic [ADDR_BITS-1:0]   slot_q, slot_d;
  logic [FILL_BITS-1:0]   fill_q, fill_d;
  logic                   out_valid_q, out_valid_d;
  bar_t                   bar_q;
  bar_t                   ram_rdata;
  logic [ADDR_BITS-1:0]   ram_raddr;

  logic [LEN_BITS-1:0]    sma_len_q   [SMA_CHANNELS];
  src_e                   sma_src_q   [SMA_CHANNELS];
  logic [ALPHA_BITS-1:0]  ema_alpha_q [EMA_CHANNELS];
  src_e                   ema_src_q   [EMA_CHANNELS];

  logic [SMA_CHANNELS-1:0] sma_clear;
  sma_ctrl_t               sma_ctrl [SMA_CHANNELS];
  sma_stat_t               sma_stat [SMA_CHANNELS];
  ema_stat_t               ema_stat [EMA_CHANNELS];

  logic [AVG_BITS-1:0]     avg_q  [SMA_CHANNELS];
  logic [SMA_CHANNELS-1:0] full_q;
  logic [EMA_BITS-1:0]     ema_q  [EMA_CHANNELS];
  logic [EMA_CHANNELS-1:0] seeded_q;
  logic [FILL_BITS-1:0]    held_q;

  logic cfg_we;
  logic bar_take;
  logic ram_we;
  logic lane_start;
  logic load_out;
  logic out_free;
  logic lanes_busy;
  logic load_done;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid && cfg_i.ready;
  assign bar_take    = bar_i.valid && bar_i.ready;
  assign out_free    = !out_valid_q || res_o.ready;
  assign load_done   = rd_q == RD_BITS'(SMA_CHANNELS);

  always_comb begin
    lanes_busy = 1'b0;
    for (int i = 0; i < SMA_CHANNELS; i++) begin
      lanes_busy = lanes_busy || sma_stat[i].busy;
    end
    for (int i = 0; i < EMA_CHANNELS; i++) begin
      lanes_busy = lanes_busy || ema_stat[i].busy;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      TOP_IDLE: if (bar_i.valid) state_d = TOP_LOAD;
      TOP_LOAD: if (load_done) state_d = TOP_RUN;
      TOP_RUN:  if (!lanes_busy) state_d = TOP_OUT;
      TOP_OUT:  if (out_free) state_d = TOP_IDLE;
    endcase
  end

  always_comb begin
    bar_i.ready = state_q == TOP_IDLE;
    ram_we      = (state_q == TOP_LOAD) && (rd_q == '0);
    lane_start  = (state_q == TOP_LOAD) && load_done;
    load_out    = (state_q == TOP_OUT) && out_free;
  end

  always_comb begin
    rd_d        = (state_q == TOP_LOAD) ? rd_q + RD_BITS'(1) : '0;
    slot_d      = slot_q;
    fill_d      = fill_q;
    out_valid_d = out_valid_q;
    if (lane_start) begin
      slot_d = (slot_q == ADDR_BITS'(HIST_DEPTH - 1)) ? '0 : slot_q + ADDR_BITS'(1);
    end
    if (ram_we && (fill_q < FILL_BITS'(HIST_DEPTH))) begin
      fill_d = fill_q + FILL_BITS'(1);
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_comb begin
    ram_raddr = slot_q;
    for (int i = 0; i < SMA_CHANNELS; i++) begin
      if (rd_q == RD_BITS'(i)) begin
        ram_raddr = back_slot(slot_q, eff_length(sma_len_q[i]));
      end
    end
  end

  always_comb begin
    for (int i = 0; i < SMA_CHANNELS; i++) begin
      sma_clear[i] = cfg_we && ((cfg_i.index == sma_reg(i, FLD_PARAM)) ||
                                (cfg_i.index == sma_reg(i, FLD_SOURCE)));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SMA_CHANNELS; i++) begin
        sma_len_q[i] <= (i == 0) ? SMA0_LEN_RESET : SMAN_LEN_RESET;
        sma_src_q[i] <= SRC_CLOSE;
      end
      for (int i = 0; i < EMA_CHANNELS; i++) begin
        ema_alpha_q[i] <= (i == 0) ? EMA0_ALPHA_RESET : EMAN_ALPHA_RESET;
        ema_src_q[i]   <= SRC_CLOSE;
      end
    end else if (cfg_we) begin
      for (int i = 0; i < SMA_CHANNELS; i++) begin
        if (cfg_i.index == sma_reg(i, FLD_PARAM)) begin
          sma_len_q[i] <= cfg_i.data[LEN_BITS-1:0];
        end
        if (cfg_i.index == sma_reg(i, FLD_SOURCE)) begin
          sma_src_q[i] <= src_e'(cfg_i.data[1:0]);
        end
      end
      for (int i = 0; i < EMA_CHANNELS; i++) begin
        if (cfg_i.index == ema_reg(i, FLD_PARAM)) begin
          ema_alpha_q[i] <= cfg_i.data[ALPHA_BITS-1:0];
        end
        if (cfg_i.index == ema_reg(i, FLD_SOURCE)) begin
          ema_src_q[i] <= src_e'(cfg_i.data[1:0]);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= TOP_IDLE;
      rd_q        <= '0;
      slot_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_q        <= rd_d;
      slot_q      <= slot_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (bar_take) begin
      bar_q.open_price  <= bar_i.open_price;
      bar_q.high_price  <= bar_i.high_price;
      bar_q.low_price   <= bar_i.low_price;
      bar_q.close_price <= bar_i.close_price;
    end
    if (load_out) begin
      for (int i = 0; i < SMA_CHANNELS; i++) begin
        avg_q[i]  <= sma_stat[i].average;
        full_q[i] <= sma_stat[i].full;
      end
      for (int i = 0; i < EMA_CHANNELS; i++) begin
        ema_q[i]    <= ema_stat[i].value;
        seeded_q[i] <= ema_stat[i].seeded;
      end
      held_q <= fill_q;
    end
  end

  bmab_ram #(
    .WIDTH (BAR_BITS),
    .DEPTH (HIST_DEPTH)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (bar_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  for (genvar g = 0; g < SMA_CHANNELS; g++) begin : g_sma
    assign sma_ctrl[g] = '{start:   lane_start,
                           clear:   sma_clear[g],
                           capture: (state_q == TOP_LOAD) && (rd_q == RD_BITS'(g + 1))};

    bmab_sma_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (sma_ctrl[g]),
      .length_i  (sma_len_q[g]),
      .source_i  (sma_src_q[g]),
      .new_bar_i (bar_q),
      .old_bar_i (ram_rdata),
      .stat_o    (sma_stat[g])
    );
  end

  for (genvar g = 0; g < EMA_CHANNELS; g++) begin : g_ema
    bmab_ema_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .start_i   (lane_start),
      .alpha_i   (ema_alpha_q[g]),
      .source_i  (ema_src_q[g]),
      .new_bar_i (bar_q),
      .stat_o    (ema_stat[g])
    );
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.sma0_average = avg_q[0];
  assign res_o.sma0_ready   = full_q[0];
  assign res_o.sma1_average = avg_q[1];
  assign res_o.sma1_ready   = full_q[1];
  assign res_o.ema0_value   = ema_q[0];
  assign res_o.ema0_ready   = seeded_q[0];
  assign res_o.ema1_value   = ema_q[1];
  assign res_o.ema1_ready   = seeded_q[1];
  assign res_o.bars_held    = held_q;

  `BMAB_ASSERT(a_idle_lanes_quiet, (state_q == TOP_IDLE) |-> !lanes_busy, "lane busy while idle")
  `BMAB_ASSERT(a_fill_bounded, fill_q <= FILL_BITS'(HIST_DEPTH), "history fill count overflow")
  `BMAB_ASSERT(a_result_from_out, $rose(out_valid_q) |-> $past(state_q) == TOP_OUT, "stray result")
  `BMAB_ASSERT_NEVER(a_write_while_busy, ram_we && lanes_busy, "history written mid-update")

endmodule
